@@ hdl/hmt_pkg.sv @@
// ----------------------------------------------------------------------------
// hmt_pkg: shared types and constants of the MAC association table
// Pool size, field widths, command and status codes, sequencer states and
// the storage request and read-data records.
// ----------------------------------------------------------------------------
package hmt_pkg;

    localparam int AP_LIMIT  = 64;
    localparam int POOL_SIZE = 3 * AP_LIMIT;
    localparam int ID_W      = 8;
    localparam int MAC_W     = 48;
    localparam int BKT_W     = 8;
    localparam int BUCKETS   = 1 << BKT_W;
    localparam int TC_W      = 4;

    localparam logic [TC_W-1:0] TYPE_2G = 4'd4;
    localparam logic [TC_W-1:0] TYPE_5G = 4'd8;

    typedef logic [ID_W-1:0]  t_id;
    typedef logic [MAC_W-1:0] t_mac;
    typedef logic [BKT_W-1:0] t_bkt;

    typedef enum logic [2:0] {
        CMD_INSERT    = 3'd0,
        CMD_CHECK     = 3'd1,
        CMD_GET_RADIO = 3'd2,
        CMD_GET_WAN   = 3'd3,
        CMD_REMOVE    = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        PH_AP, PH_2G, PH_5G, PH_R2, PH_R5, PH_RA
    } t_phase;

    typedef enum logic [3:0] {
        S_IDLE, S_DISP, S_F_BKT, S_F_HD, S_F_CMP, S_F_END,
        S_ALLOC, S_ALLOC_RD, S_ALLOC_W1, S_ALLOC_W2, S_INS_DONE,
        S_GET_RD, S_RM_RD, S_RMV_RD, S_OUT
    } t_state;

    typedef struct packed {
        logic [2:0]      command;
        t_mac            key_mac;
        logic            has_mac_2g;
        t_mac            mac_2g_in;
        logic            has_mac_5g;
        t_mac            mac_5g_in;
        logic [TC_W-1:0] type_code;
    } t_req;

    typedef struct packed {
        logic [1:0] status;
        t_id        entry_id;
        logic       mac_valid;
        t_mac       result_mac;
    } t_rsp;

    typedef struct packed {
        t_mac            key;
        t_id             hprev;
        t_id             hnext;
        t_id             fnext;
        logic [TC_W-1:0] etype;
        logic            wan_f;
        logic            g2_f;
        logic            g5_f;
        t_mac            wan;
        t_mac            mac2g;
        t_mac            mac5g;
    } t_ent;

    typedef struct packed {
        logic key_we;
        logic hprev_we;
        logic hnext_we;
        logic fnext_we;
        logic etype_we;
        logic wan_f_we;
        logic g2_f_we;
        logic g5_f_we;
        logic wan_we;
        logic mac2g_we;
        logic mac5g_we;
        t_id  key_addr;
        t_id  hprev_addr;
        t_id  hnext_addr;
        t_id  fnext_addr;
        t_id  etype_addr;
        t_id  wan_f_addr;
        t_id  g2_f_addr;
        t_id  g5_f_addr;
        t_id  wan_addr;
        t_id  mac2g_addr;
        t_id  mac5g_addr;
        t_ent data;
        logic bkt_we;
        t_bkt bkt_addr;
        t_id  bkt_data;
    } t_wr;

endpackage

@@ hdl/hmt_if.sv @@
// ----------------------------------------------------------------------------
// hmt_req_if / hmt_rsp_if: request and response channels
// Valid/ready channels carrying one command item or one result item.
// ----------------------------------------------------------------------------
interface hmt_req_if import hmt_pkg::*; ;
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface hmt_rsp_if import hmt_pkg::*; ;
    logic valid;
    logic ready;
    t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ hdl/hmt_store.sv @@
// ----------------------------------------------------------------------------
// hmt_store: bucket heads and entry pool
// Bucket head memory with per-bucket valid bits, and one memory per entry
// field, each with one write port and a registered read at a shared address.
// ----------------------------------------------------------------------------
module hmt_store import hmt_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_id  i_raddr,
    input  t_bkt i_braddr,
    input  t_wr  i_wr,
    output t_ent o_rd,
    output t_id  o_bkt_rd
);

    t_mac            m_key   [0:POOL_SIZE];
    t_id             m_hprev [0:POOL_SIZE];
    t_id             m_hnext [0:POOL_SIZE];
    t_id             m_fnext [0:POOL_SIZE];
    logic [TC_W-1:0] m_etype [0:POOL_SIZE];
    logic            m_wan_f [0:POOL_SIZE];
    logic            m_g2_f  [0:POOL_SIZE];
    logic            m_g5_f  [0:POOL_SIZE];
    t_mac            m_wan   [0:POOL_SIZE];
    t_mac            m_mac2g [0:POOL_SIZE];
    t_mac            m_mac5g [0:POOL_SIZE];
    t_id             m_bkt   [0:BUCKETS-1];

    logic [BUCKETS-1:0] r_bvld;
    t_ent r_rd;
    t_id  r_bkt_rd;
    logic r_bkt_hit;

    always_ff @(posedge i_clk) begin
        if (i_wr.key_we)   m_key[i_wr.key_addr]     <= i_wr.data.key;
        if (i_wr.hprev_we) m_hprev[i_wr.hprev_addr] <= i_wr.data.hprev;
        if (i_wr.hnext_we) m_hnext[i_wr.hnext_addr] <= i_wr.data.hnext;
        if (i_wr.fnext_we) m_fnext[i_wr.fnext_addr] <= i_wr.data.fnext;
        if (i_wr.etype_we) m_etype[i_wr.etype_addr] <= i_wr.data.etype;
        if (i_wr.wan_f_we) m_wan_f[i_wr.wan_f_addr] <= i_wr.data.wan_f;
        if (i_wr.g2_f_we)  m_g2_f[i_wr.g2_f_addr]   <= i_wr.data.g2_f;
        if (i_wr.g5_f_we)  m_g5_f[i_wr.g5_f_addr]   <= i_wr.data.g5_f;
        if (i_wr.wan_we)   m_wan[i_wr.wan_addr]     <= i_wr.data.wan;
        if (i_wr.mac2g_we) m_mac2g[i_wr.mac2g_addr] <= i_wr.data.mac2g;
        if (i_wr.mac5g_we) m_mac5g[i_wr.mac5g_addr] <= i_wr.data.mac5g;
        if (i_wr.bkt_we)   m_bkt[i_wr.bkt_addr]     <= i_wr.bkt_data;
    end

    always_ff @(posedge i_clk) begin
        r_rd.key   <= m_key[i_raddr];
        r_rd.hprev <= m_hprev[i_raddr];
        r_rd.hnext <= m_hnext[i_raddr];
        r_rd.fnext <= m_fnext[i_raddr];
        r_rd.etype <= m_etype[i_raddr];
        r_rd.wan_f <= m_wan_f[i_raddr];
        r_rd.g2_f  <= m_g2_f[i_raddr];
        r_rd.g5_f  <= m_g5_f[i_raddr];
        r_rd.wan   <= m_wan[i_raddr];
        r_rd.mac2g <= m_mac2g[i_raddr];
        r_rd.mac5g <= m_mac5g[i_raddr];
        r_bkt_rd   <= m_bkt[i_braddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bvld    <= '0;
            r_bkt_hit <= 1'b0;
        end else begin
            r_bkt_hit <= r_bvld[i_braddr];
            if (i_wr.bkt_we) r_bvld[i_wr.bkt_addr] <= 1'b1;
        end
    end

    assign o_rd     = r_rd;
    assign o_bkt_rd = r_bkt_hit ? r_bkt_rd : '0;

endmodule

@@ hdl/hmt_seq.sv @@
// ----------------------------------------------------------------------------
// hmt_seq: command sequencer
// Walks hash chains with one shared key comparator, allocates and frees pool
// entries, links radio entries and builds the result item.
// ----------------------------------------------------------------------------
module hmt_seq import hmt_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    hmt_req_if.sink   i_req,
    hmt_rsp_if.source o_rsp,
    input  t_ent i_rd,
    input  t_id  i_bkt_rd,
    output t_id  o_raddr,
    output t_bkt o_braddr,
    output t_wr  o_wr
);

    t_state r_state, n_state;
    t_phase r_phase, n_phase;
    logic [2:0] r_cmd, n_cmd;
    t_mac r_key, n_key, r_m2, n_m2, r_m5, n_m5, r_ok, n_ok;
    t_mac r_k2, n_k2, r_k5, n_k5, r_mac, n_mac;
    logic r_h2, n_h2, r_h5, n_h5, r_r2, n_r2, r_r5, n_r5, r_mv, n_mv;
    logic [TC_W-1:0] r_tc, n_tc;
    logic [1:0] r_status, n_status;
    t_id r_cur, n_cur, r_fid, n_fid, r_id, n_id, r_bhead, n_bhead;
    t_id r_free_head, n_free_head, r_nfree, n_nfree, r_hw, n_hw;

    logic [ID_W:0] hw_p1, hw_p2;
    t_phase np;

    function automatic t_phase rm_after(t_phase p, logic r2, logic r5);
        case (p)
            PH_AP:   rm_after = r2 ? PH_R2 : (r5 ? PH_R5 : PH_RA);
            PH_R2:   rm_after = r5 ? PH_R5 : PH_RA;
            PH_R5:   rm_after = PH_RA;
            default: rm_after = PH_AP;
        endcase
    endfunction

    function automatic t_phase ins_after(t_phase p, logic h2, logic h5);
        case (p)
            PH_AP:   ins_after = h2 ? PH_2G : (h5 ? PH_5G : PH_AP);
            PH_2G:   ins_after = h5 ? PH_5G : PH_AP;
            default: ins_after = PH_AP;
        endcase
    endfunction

    assign hw_p1 = {1'b0, r_hw} + (ID_W+1)'(1);
    assign hw_p2 = {1'b0, r_hw} + (ID_W+1)'(2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_free_head <= t_id'(1);
            r_hw        <= '0;
        end else begin
            r_state     <= n_state;
            r_free_head <= n_free_head;
            r_hw        <= n_hw;
        end
    end

    always_ff @(posedge i_clk) begin
        r_phase  <= n_phase;
        r_cmd    <= n_cmd;
        r_key    <= n_key;
        r_m2     <= n_m2;
        r_m5     <= n_m5;
        r_ok     <= n_ok;
        r_k2     <= n_k2;
        r_k5     <= n_k5;
        r_mac    <= n_mac;
        r_h2     <= n_h2;
        r_h5     <= n_h5;
        r_r2     <= n_r2;
        r_r5     <= n_r5;
        r_mv     <= n_mv;
        r_tc     <= n_tc;
        r_status <= n_status;
        r_cur    <= n_cur;
        r_fid    <= n_fid;
        r_id     <= n_id;
        r_bhead  <= n_bhead;
        r_nfree  <= n_nfree;
    end

    always_comb begin
        n_state = r_state;  n_phase = r_phase;  n_cmd = r_cmd;
        n_key = r_key;  n_m2 = r_m2;  n_m5 = r_m5;  n_ok = r_ok;
        n_k2 = r_k2;  n_k5 = r_k5;  n_mac = r_mac;
        n_h2 = r_h2;  n_h5 = r_h5;  n_r2 = r_r2;  n_r5 = r_r5;  n_mv = r_mv;
        n_tc = r_tc;  n_status = r_status;  n_cur = r_cur;  n_fid = r_fid;
        n_id = r_id;  n_bhead = r_bhead;  n_free_head = r_free_head;
        n_nfree = r_nfree;  n_hw = r_hw;
        np = PH_AP;
        o_raddr  = r_cur;
        o_braddr = r_ok[BKT_W-1:0];
        o_wr     = '0;
        i_req.ready = 1'b0;
        o_rsp.valid = 1'b0;
        o_rsp.data  = '{status: r_status, entry_id: r_id, mac_valid: r_mv,
                        result_mac: r_mac};

        case (r_state)
            S_IDLE: begin
                i_req.ready = 1'b1;
                if (i_req.valid) begin
                    n_cmd    = i_req.data.command;
                    n_key    = i_req.data.key_mac;
                    n_ok     = i_req.data.key_mac;
                    n_h2     = i_req.data.has_mac_2g;
                    n_m2     = i_req.data.mac_2g_in;
                    n_h5     = i_req.data.has_mac_5g;
                    n_m5     = i_req.data.mac_5g_in;
                    n_tc     = i_req.data.type_code;
                    n_phase  = PH_AP;
                    n_status = ST_OK;
                    n_id     = '0;
                    n_mv     = 1'b0;
                    n_mac    = '0;
                    n_state  = S_DISP;
                end
            end
            S_DISP: begin
                if (r_cmd <= CMD_REMOVE) begin
                    n_state = S_F_BKT;
                end else begin
                    n_status = ST_MISS;
                    n_state  = S_OUT;
                end
            end
            S_F_BKT: n_state = S_F_HD;
            S_F_HD: begin
                n_bhead = i_bkt_rd;
                if (i_bkt_rd == '0) begin
                    n_fid   = '0;
                    n_state = S_F_END;
                end else begin
                    o_raddr = i_bkt_rd;
                    n_cur   = i_bkt_rd;
                    n_state = S_F_CMP;
                end
            end
            S_F_CMP: begin
                if (i_rd.key == r_ok) begin
                    n_fid   = r_cur;
                    n_state = S_F_END;
                end else if (i_rd.hnext == '0) begin
                    n_fid   = '0;
                    n_state = S_F_END;
                end else begin
                    o_raddr = i_rd.hnext;
                    n_cur   = i_rd.hnext;
                end
            end
            S_F_END: begin
                if (r_phase == PH_R2 || r_phase == PH_R5 || r_phase == PH_RA) begin
                    if (r_fid == '0) begin
                        np = rm_after(r_phase, r_r2, r_r5);
                        if (np == PH_AP) begin
                            n_state = S_OUT;
                        end else begin
                            n_phase = np;
                            n_ok    = (np == PH_R5) ? r_k5 : r_key;
                            n_state = S_F_BKT;
                        end
                    end else begin
                        o_raddr = r_fid;
                        n_state = S_RMV_RD;
                    end
                end else if (r_cmd == CMD_INSERT) begin
                    n_state = (r_fid != '0) ? S_INS_DONE : S_ALLOC;
                end else if (r_fid == '0) begin
                    n_status = ST_MISS;
                    n_state  = S_OUT;
                end else begin
                    n_id    = r_fid;
                    o_raddr = r_fid;
                    if (r_cmd == CMD_CHECK)       n_state = S_OUT;
                    else if (r_cmd == CMD_REMOVE) n_state = S_RM_RD;
                    else                          n_state = S_GET_RD;
                end
            end
            S_ALLOC: begin
                if (r_free_head == '0) begin
                    n_fid   = '0;
                    n_state = S_INS_DONE;
                end else if ({1'b0, r_free_head} == hw_p1) begin
                    n_nfree = (hw_p2 <= (ID_W+1)'(POOL_SIZE)) ? hw_p2[ID_W-1:0] : '0;
                    n_hw    = hw_p1[ID_W-1:0];
                    n_state = S_ALLOC_W1;
                end else begin
                    o_raddr = r_free_head;
                    n_state = S_ALLOC_RD;
                end
            end
            S_ALLOC_RD: begin
                n_nfree = i_rd.fnext;
                n_state = S_ALLOC_W1;
            end
            S_ALLOC_W1: begin
                o_wr.key_we     = 1'b1;  o_wr.key_addr   = r_free_head;
                o_wr.data.key   = r_ok;
                o_wr.hprev_we   = 1'b1;  o_wr.hprev_addr = r_free_head;
                o_wr.data.hprev = '0;
                o_wr.hnext_we   = 1'b1;  o_wr.hnext_addr = r_free_head;
                o_wr.data.hnext = r_bhead;
                o_wr.etype_we   = 1'b1;  o_wr.etype_addr = r_free_head;
                o_wr.data.etype = '0;
                o_wr.wan_f_we   = 1'b1;  o_wr.wan_f_addr = r_free_head;
                o_wr.data.wan_f = 1'b0;
                o_wr.g2_f_we    = 1'b1;  o_wr.g2_f_addr  = r_free_head;
                o_wr.data.g2_f  = 1'b0;
                o_wr.g5_f_we    = 1'b1;  o_wr.g5_f_addr  = r_free_head;
                o_wr.data.g5_f  = 1'b0;
                o_wr.bkt_we     = 1'b1;  o_wr.bkt_addr   = r_ok[BKT_W-1:0];
                o_wr.bkt_data   = r_free_head;
                n_fid       = r_free_head;
                n_free_head = r_nfree;
                n_state     = S_ALLOC_W2;
            end
            S_ALLOC_W2: begin
                if (r_bhead != '0) begin
                    o_wr.hprev_we   = 1'b1;
                    o_wr.hprev_addr = r_bhead;
                    o_wr.data.hprev = r_fid;
                end
                n_state = S_INS_DONE;
            end
            S_INS_DONE: begin
                np = ins_after(r_phase, r_h2, r_h5);
                if (r_phase == PH_AP && r_fid == '0) begin
                    n_status = ST_FULL;
                    np       = PH_AP;
                end else if (r_phase == PH_AP) begin
                    n_id = r_fid;
                    o_wr.etype_we   = 1'b1;
                    o_wr.etype_addr = r_fid;
                    o_wr.data.etype = r_tc;
                end else if (r_fid == '0) begin
                    n_status = ST_FULL;
                end else begin
                    o_wr.etype_we   = 1'b1;  o_wr.etype_addr = r_fid;
                    o_wr.wan_f_we   = 1'b1;  o_wr.wan_f_addr = r_fid;
                    o_wr.data.wan_f = 1'b1;
                    o_wr.wan_we     = 1'b1;  o_wr.wan_addr   = r_fid;
                    o_wr.data.wan   = r_key;
                    if (r_phase == PH_2G) begin
                        o_wr.data.etype = TYPE_2G;
                        o_wr.g2_f_we    = 1'b1;  o_wr.g2_f_addr  = r_id;
                        o_wr.data.g2_f  = 1'b1;
                        o_wr.mac2g_we   = 1'b1;  o_wr.mac2g_addr = r_id;
                        o_wr.data.mac2g = r_m2;
                    end else begin
                        o_wr.data.etype = TYPE_5G;
                        o_wr.g5_f_we    = 1'b1;  o_wr.g5_f_addr  = r_id;
                        o_wr.data.g5_f  = 1'b1;
                        o_wr.mac5g_we   = 1'b1;  o_wr.mac5g_addr = r_id;
                        o_wr.data.mac5g = r_m5;
                    end
                end
                if (np == PH_AP) begin
                    n_state = S_OUT;
                end else begin
                    n_phase = np;
                    n_ok    = (np == PH_2G) ? r_m2 : r_m5;
                    n_state = S_F_BKT;
                end
            end
            S_GET_RD: begin
                if (r_cmd == CMD_GET_WAN) begin
                    if (i_rd.wan_f) begin
                        n_mv  = 1'b1;
                        n_mac = i_rd.wan;
                    end
                end else if (r_tc == TYPE_2G && i_rd.g2_f) begin
                    n_mv  = 1'b1;
                    n_mac = i_rd.mac2g;
                end else if (r_tc == TYPE_5G && i_rd.g5_f) begin
                    n_mv  = 1'b1;
                    n_mac = i_rd.mac5g;
                end
                n_state = S_OUT;
            end
            S_RM_RD: begin
                n_r2 = i_rd.g2_f;
                n_r5 = i_rd.g5_f;
                n_k2 = i_rd.mac2g;
                n_k5 = i_rd.mac5g;
                np   = rm_after(PH_AP, i_rd.g2_f, i_rd.g5_f);
                n_phase = np;
                if (np == PH_R2)      n_ok = i_rd.mac2g;
                else if (np == PH_R5) n_ok = i_rd.mac5g;
                else                  n_ok = r_key;
                n_state = S_F_BKT;
            end
            S_RMV_RD: begin
                if (i_rd.hprev != '0) begin
                    o_wr.hnext_we   = 1'b1;
                    o_wr.hnext_addr = i_rd.hprev;
                    o_wr.data.hnext = i_rd.hnext;
                end else begin
                    o_wr.bkt_we   = 1'b1;
                    o_wr.bkt_addr = r_ok[BKT_W-1:0];
                    o_wr.bkt_data = i_rd.hnext;
                end
                if (i_rd.hnext != '0) begin
                    o_wr.hprev_we   = 1'b1;
                    o_wr.hprev_addr = i_rd.hnext;
                    o_wr.data.hprev = i_rd.hprev;
                end
                o_wr.fnext_we   = 1'b1;
                o_wr.fnext_addr = r_fid;
                o_wr.data.fnext = r_free_head;
                n_free_head     = r_fid;
                np = rm_after(r_phase, r_r2, r_r5);
                if (np == PH_AP) begin
                    n_state = S_OUT;
                end else begin
                    n_phase = np;
                    n_ok    = (np == PH_R5) ? r_k5 : r_key;
                    n_state = S_F_BKT;
                end
            end
            S_OUT: begin
                o_rsp.valid = 1'b1;
                if (o_rsp.ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

@@ hdl/mac_association_hash_table_unit.sv @@
// ----------------------------------------------------------------------------
// mac_association_hash_table_unit: MAC association hash table
// Chained hash table of MAC keys over 256 buckets with a free-list pool;
// insert, check, get radio MAC, get WAN MAC and remove commands.
//
//   channel   dir   payload
//   i_req     in    command, key_mac, has_mac_2g, mac_2g_in, has_mac_5g,
//                   mac_5g_in, type_code
//   o_rsp     out   status, entry_id, mac_valid, result_mac
//
// One command at a time. A chain lookup reads the bucket head, then compares
// the chain entries one by one against the key in the shared key comparator;
// insert adds entry allocation and radio linking, and remove unlinks each
// entry found. Command time grows with the lengths of the chains walked, as
// entry fields are read through a single shared address.
// Reset clears the bucket valid bits at once; no clearing pass.
// A stalled result holds the block in output.
// ----------------------------------------------------------------------------
module mac_association_hash_table_unit import hmt_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    hmt_req_if.sink   i_req,
    hmt_rsp_if.source o_rsp
);

    t_ent rd;
    t_id  bkt_rd;
    t_id  raddr;
    t_bkt braddr;
    t_wr  wr;

    hmt_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (i_req),
        .o_rsp    (o_rsp),
        .i_rd     (rd),
        .i_bkt_rd (bkt_rd),
        .o_raddr  (raddr),
        .o_braddr (braddr),
        .o_wr     (wr)
    );

    hmt_store u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_raddr  (raddr),
        .i_braddr (braddr),
        .i_wr     (wr),
        .o_rd     (rd),
        .o_bkt_rd (bkt_rd)
    );

endmodule

@@ tb/tb_mac_association_hash_table_unit.sv @@
// ----------------------------------------------------------------------------
// tb_mac_association_hash_table_unit: MAC association table testbench
// Drives insert, lookup, remove and invalid commands over the request channel with
// bursty idling, predicts each result with a behavioral table model and
// compares every result item field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_mac_association_hash_table_unit;
    import hmt_pkg::*;

    typedef struct {
        t_id             hprev;
        t_id             hnext;
        t_id             fnext;
        logic [TC_W-1:0] etype;
        bit              wan_f;
        bit              g2_f;
        bit              g5_f;
        t_mac            wan;
        t_mac            mac2g;
        t_mac            mac5g;
    } t_slot;

    class table_scoreboard;
        t_id   head_of[BUCKETS];
        t_mac  key_of[POOL_SIZE+1];
        t_slot slot[POOL_SIZE+1];
        t_id   free_id;
        t_rsp  pending[$];
        int    errors;

        function new();
            t_slot z;
            z = '{default: 0};
            foreach (head_of[i]) head_of[i] = 0;
            for (int i = 0; i <= POOL_SIZE; i++) begin
                key_of[i] = 0;
                slot[i] = z;
                if (i >= 1 && i < POOL_SIZE) slot[i].fnext = t_id'(i + 1);
            end
            free_id = 1;
            errors = 0;
        endfunction

        function int lookup(t_mac k);
            int id;
            int steps;
            id = head_of[k[7:0]];
            steps = 0;
            while (id != 0 && id <= POOL_SIZE && steps <= POOL_SIZE) begin
                if (key_of[id] == k) return id;
                id = slot[id].hnext;
                steps++;
            end
            return 0;
        endfunction

        function int claim(t_mac k);
            int id;
            t_slot z;
            t_id h;
            z = '{default: 0};
            id = lookup(k);
            if (id != 0) return id;
            id = free_id;
            if (id == 0 || id > POOL_SIZE) return 0;
            free_id = slot[id].fnext;
            slot[id] = z;
            key_of[id] = k;
            h = head_of[k[7:0]];
            slot[id].hnext = h;
            if (h != 0 && h <= POOL_SIZE) slot[h].hprev = t_id'(id);
            head_of[k[7:0]] = t_id'(id);
            return id;
        endfunction

        function void unlink(t_mac k);
            int id;
            t_id p;
            t_id n;
            id = lookup(k);
            if (id == 0) return;
            p = slot[id].hprev;
            n = slot[id].hnext;
            if (p != 0 && p <= POOL_SIZE) slot[p].hnext = n;
            else head_of[k[7:0]] = n;
            if (n != 0 && n <= POOL_SIZE) slot[n].hprev = p;
            slot[id].hprev = 0;
            slot[id].hnext = 0;
            slot[id].fnext = free_id;
            free_id = t_id'(id);
        endfunction

        function void note_command(t_req r);
            t_rsp e;
            int id;
            int x;
            t_slot s;
            e = '0;
            if (r.command == CMD_INSERT) begin
                id = claim(r.key_mac);
                if (id == 0) e.status = ST_FULL;
                else begin
                    slot[id].etype = r.type_code;
                    if (r.has_mac_2g) begin
                        x = claim(r.mac_2g_in);
                        if (x == 0) e.status = ST_FULL;
                        else begin
                            slot[id].g2_f = 1;
                            slot[id].mac2g = r.mac_2g_in;
                            slot[x].etype = TYPE_2G;
                            slot[x].wan_f = 1;
                            slot[x].wan = r.key_mac;
                        end
                    end
                    if (r.has_mac_5g) begin
                        x = claim(r.mac_5g_in);
                        if (x == 0) e.status = ST_FULL;
                        else begin
                            slot[id].g5_f = 1;
                            slot[id].mac5g = r.mac_5g_in;
                            slot[x].etype = TYPE_5G;
                            slot[x].wan_f = 1;
                            slot[x].wan = r.key_mac;
                        end
                    end
                end
            end else if (r.command <= CMD_REMOVE) begin
                id = lookup(r.key_mac);
                if (id == 0) e.status = ST_MISS;
                else begin
                    s = slot[id];
                    if (r.command == CMD_GET_RADIO) begin
                        if (r.type_code == TYPE_2G && s.g2_f) begin
                            e.mac_valid = 1;
                            e.result_mac = s.mac2g;
                        end else if (r.type_code == TYPE_5G && s.g5_f) begin
                            e.mac_valid = 1;
                            e.result_mac = s.mac5g;
                        end
                    end else if (r.command == CMD_GET_WAN) begin
                        if (s.wan_f) begin
                            e.mac_valid = 1;
                            e.result_mac = s.wan;
                        end
                    end else if (r.command == CMD_REMOVE) begin
                        if (s.g2_f) unlink(s.mac2g);
                        if (s.g5_f) unlink(s.mac5g);
                        unlink(r.key_mac);
                    end
                end
            end else e.status = ST_MISS;
            e.entry_id = t_id'(id);
            if (r.command > CMD_REMOVE) e.entry_id = 0;
            pending.push_back(e);
        endfunction

        task check_result(t_rsp got);
            t_rsp e;
            if (pending.size() == 0) begin
                report("result with nothing expected");
                return;
            end
            e = pending.pop_front();
            if (got.status !== e.status)
                report($sformatf("status %0d, expected %0d", got.status, e.status));
            if (got.entry_id !== e.entry_id)
                report($sformatf("entry_id %0d, expected %0d", got.entry_id, e.entry_id));
            if (got.mac_valid !== e.mac_valid)
                report($sformatf("mac_valid %0b, expected %0b", got.mac_valid, e.mac_valid));
            if (got.result_mac !== e.result_mac)
                report($sformatf("result_mac %h, expected %h", got.result_mac, e.result_mac));
        endtask

        task report(string msg);
            $display("mismatch at %0t: %s", $time, msg);
            errors++;
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;
    hmt_req_if req_ch();
    hmt_rsp_if rsp_ch();
    table_scoreboard sb;
    t_mac known[$];
    int burst_left;

    mac_association_hash_table_unit DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch.sink),
        .o_rsp  (rsp_ch.source)
    );

    initial i_clk = 0;
    always #2 i_clk = ~i_clk;

    initial begin
        #20000000;
        $display("RESULT: ERROR");
        $finish;
    end

    // receiver stall pattern: an open stretch, then stretches of random stalls
    int stall_ctr = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 0;
            stall_ctr <= 0;
        end else begin
            stall_ctr <= (stall_ctr + 1) % 96;
            if (stall_ctr < 40) rsp_ch.ready <= 1;
            else if (stall_ctr < 70) rsp_ch.ready <= ($urandom_range(0, 2) != 0);
            else rsp_ch.ready <= ($urandom_range(0, 4) == 0);
            if (rsp_ch.valid && rsp_ch.ready) sb.check_result(rsp_ch.data);
        end
    end

    task automatic send(t_req r);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap != 0) begin
                req_ch.valid <= 0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        req_ch.data <= r;
        req_ch.valid <= 1;
        do @(posedge i_clk); while (!req_ch.ready);
        sb.note_command(r);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        req_ch.valid <= 0;
        while (sb.pending.size() != 0 && guard < 100000) begin
            @(posedge i_clk);
            guard++;
        end
    endtask

    function automatic t_mac pick_key();
        t_mac m;
        if (known.size() != 0 && $urandom_range(0, 3) != 0)
            return known[$urandom_range(0, known.size() - 1)];
        m = t_mac'({$urandom, $urandom});
        if ($urandom_range(0, 1)) m[7:0] = 8'($urandom_range(0, 3));
        return m;
    endfunction

    function automatic t_req make_insert(t_mac ap, bit h2, bit h5, logic [3:0] tc);
        t_req r;
        r = '0;
        r.command = CMD_INSERT;
        r.key_mac = ap;
        r.has_mac_2g = h2;
        r.mac_2g_in = t_mac'({$urandom, $urandom});
        r.mac_2g_in[7:0] = ap[7:0] + 8'd1;
        r.has_mac_5g = h5;
        r.mac_5g_in = t_mac'({$urandom, $urandom});
        r.type_code = tc;
        return r;
    endfunction

    task automatic send_cmd(t_cmd c, t_mac k, logic [3:0] tc);
        t_req r;
        r = '0;
        r.command = c;
        r.key_mac = k;
        r.type_code = tc;
        r.mac_2g_in = t_mac'({$urandom, $urandom});
        r.mac_5g_in = t_mac'({$urandom, $urandom});
        r.has_mac_2g = 1'($urandom_range(0, 1));
        r.has_mac_5g = 1'($urandom_range(0, 1));
        send(r);
    endtask

    task automatic random_item(bit grow);
        t_req r;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < (grow ? 55 : 25)) begin
            r = make_insert(pick_key(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                            4'($urandom_range(0, 15)));
            if ($urandom_range(0, 7) == 0) r.mac_2g_in = pick_key();
            if ($urandom_range(0, 7) == 0) r.mac_5g_in = r.key_mac;
            known.push_back(r.key_mac);
            if (r.has_mac_2g) known.push_back(r.mac_2g_in);
            if (r.has_mac_5g) known.push_back(r.mac_5g_in);
            if (known.size() > 400) known.delete(0);
            send(r);
        end else if (pick < 45) send_cmd(CMD_CHECK, pick_key(), 4'($urandom_range(0, 15)));
        else if (pick < 65)
            send_cmd(CMD_GET_RADIO, pick_key(),
                     $urandom_range(0, 4) == 0 ? 4'($urandom_range(0, 15)) :
                     ($urandom_range(0, 1) ? TYPE_2G : TYPE_5G));
        else if (pick < 80) send_cmd(CMD_GET_WAN, pick_key(), 4'($urandom_range(0, 15)));
        else if (pick < 97 - (grow ? 12 : 0)) send_cmd(CMD_REMOVE, pick_key(), 4'h0);
        else send_cmd(t_cmd'(3'($urandom_range(5, 7))), pick_key(), 4'($urandom_range(0, 15)));
    endtask

    initial begin
        t_req r;
        sb = new();
        burst_left = 0;
        i_rst_n = 0;
        req_ch.valid = 0;
        req_ch.data = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        r = make_insert(48'hFFFF_FFFF_FFFF, 1, 1, 4'd1);
        r.mac_2g_in = 48'h0;
        r.mac_5g_in = 48'hAAAA_5555_AAFF;
        send(r);
        send_cmd(CMD_CHECK, 48'hFFFF_FFFF_FFFF, 4'hF);
        send_cmd(CMD_GET_RADIO, 48'hFFFF_FFFF_FFFF, TYPE_2G);
        send_cmd(CMD_GET_RADIO, 48'hFFFF_FFFF_FFFF, TYPE_5G);
        send_cmd(CMD_GET_RADIO, 48'hFFFF_FFFF_FFFF, 4'd3);
        send_cmd(CMD_GET_WAN, 48'h0, 4'h0);
        send_cmd(CMD_GET_WAN, 48'hFFFF_FFFF_FFFF, 4'h0);
        send_cmd(CMD_CHECK, 48'h1234_5678_9AFF, 4'h0);
        r = make_insert(48'h5555_5555_5501, 1, 1, 4'd2);
        r.mac_2g_in = 48'h5555_5555_5501;
        r.mac_5g_in = 48'h5555_5555_5501;
        send(r);
        send_cmd(CMD_GET_WAN, 48'h5555_5555_5501, 4'h0);
        send_cmd(CMD_GET_RADIO, 48'h5555_5555_5501, TYPE_5G);
        send_cmd(t_cmd'(3'd7), 48'h5555_5555_5501, 4'hF);
        send_cmd(t_cmd'(3'd5), 48'h0, 4'h0);
        send_cmd(CMD_REMOVE, 48'hFFFF_FFFF_FFFF, 4'h0);
        send_cmd(CMD_CHECK, 48'h0, 4'h0);
        send_cmd(CMD_REMOVE, 48'hFFFF_FFFF_FFFF, 4'h0);
        send_cmd(CMD_REMOVE, 48'h5555_5555_5501, 4'h0);
        drain();

        // fill the pool to reach the table-full cases
        for (int i = 0; i < 75; i++) begin
            r = make_insert(t_mac'({$urandom, $urandom}), 1, 1, 4'($urandom_range(0, 15)));
            r.key_mac[7:0] = 8'(i % 4);
            known.push_back(r.key_mac);
            send(r);
        end
        for (int i = 0; i < 1560; i++) random_item((i / 300) % 2 == 0);

        drain();
        repeat (200) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) $display("RESULT: OK");
        else $display("RESULT: ERROR");
        $finish;
    end
endmodule
